// File: rtl/ucg_pkg.sv
// ucg_pkg: shared types, constants and the CAN ID table of the UART/CAN frame gateway.
// Used by every module of the gateway and by its checker.
package ucg_pkg;

  localparam int FRAME_BYTES_DEF   = 12;
  localparam int TABLE_ENTRIES_DEF = 11;
  localparam int MAX_FRAME_BYTES   = 12;
  localparam int ID_TABLE_LEN      = 11;
  localparam int UART_BEATS        = 14;
  localparam int QUEUE_DEPTH       = 2;

  localparam int MBOX_W     = 4;
  localparam int PAYLOAD_W  = 64;
  localparam int BYTE_W     = 8;
  localparam int CAN_ID_W   = 11;
  localparam int S_DATA_W   = 88;
  localparam int M_DATA_W   = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC  = 2'd0,
    CFG_END   = 2'd1,
    CFG_REPLY = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] ID_TABLE [ID_TABLE_LEN] = '{
    32'h111, 32'h112, 32'h130, 32'h131, 32'h140, 32'h141,
    32'h150, 32'h151, 32'h101, 32'h160, 32'h161
  };

  typedef struct packed {
    logic                  to_uart;
    logic [MBOX_W-1:0]     mailbox;
    logic [PAYLOAD_W-1:0]  payload;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_wr_t;

endpackage

// File: rtl/ucg_front.sv
// ucg_front: UART frame parser and CAN reply-ID filter; turns accepted beats into jobs.
// Depends on ucg_pkg.
module ucg_front #(
  parameter int FRAME_BYTES   = ucg_pkg::FRAME_BYTES_DEF,
  parameter int TABLE_ENTRIES = ucg_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          func_i,
  input  logic [ucg_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [ucg_pkg::CAN_ID_W-1:0]  frame_id_i,
  input  logic [ucg_pkg::PAYLOAD_W-1:0] payload_i,
  input  logic [ucg_pkg::BYTE_W-1:0]    sync_byte_i,
  input  logic [ucg_pkg::CAN_ID_W-1:0]  reply_id_i,
  output ucg_pkg::q_wr_t                q_wr_o
);
  import ucg_pkg::*;

  localparam int IdxW   = $clog2(FRAME_BYTES);
  localparam int MatchN = (TABLE_ENTRIES < ID_TABLE_LEN) ? TABLE_ENTRIES : ID_TABLE_LEN;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);

  logic            collecting_q, collecting_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] store_q [FRAME_BYTES];
  logic [BYTE_W-1:0] fb [MAX_FRAME_BYTES];
  logic [31:0]       frame_id;
  logic [PAYLOAD_W-1:0] frame_pay;
  logic              hit;
  logic [MBOX_W-1:0] mbox;
  logic              uart_beat;
  logic              frame_done;

  assign uart_beat  = in_valid_i && !func_i;
  assign frame_done = uart_beat && collecting_q && (idx_q == LastIdx);

  always_comb begin
    collecting_d = collecting_q;
    idx_d        = idx_q;
    if (uart_beat) begin
      if (!collecting_q) begin
        if (rx_byte_i == sync_byte_i) begin
          collecting_d = 1'b1;
          idx_d        = '0;
        end
      end else if (idx_q == LastIdx) begin
        collecting_d = 1'b0;
        idx_d        = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uart_beat && collecting_q) begin
      store_q[idx_q] <= rx_byte_i;
    end
  end

  for (genvar p = 0; p < MAX_FRAME_BYTES; p++) begin : g_fb
    if (p < FRAME_BYTES - 1) begin : g_stored
      assign fb[p] = store_q[p];
    end else if (p == FRAME_BYTES - 1) begin : g_incoming
      assign fb[p] = rx_byte_i;
    end else begin : g_zero
      assign fb[p] = '0;
    end
  end

  assign frame_id  = {fb[0], fb[1], fb[2], fb[3]};
  assign frame_pay = {fb[4], fb[5], fb[6], fb[7], fb[8], fb[9], fb[10], fb[11]};

  always_comb begin
    hit  = 1'b0;
    mbox = '0;
    for (int i = MatchN - 1; i >= 0; i--) begin
      if (frame_id == ID_TABLE[i]) begin
        hit  = 1'b1;
        mbox = MBOX_W'(i);
      end
    end
  end

  always_comb begin
    q_wr_o.valid       = 1'b0;
    q_wr_o.job.to_uart = func_i;
    q_wr_o.job.mailbox = '0;
    q_wr_o.job.payload = payload_i;
    if (in_valid_i && func_i) begin
      q_wr_o.valid = (frame_id_i == reply_id_i);
    end else begin
      q_wr_o.valid       = frame_done && hit;
      q_wr_o.job.mailbox = mbox;
      q_wr_o.job.payload = frame_pay;
    end
  end

endmodule

// File: rtl/ucg_fifo.sv
// ucg_fifo: short job queue between the parser and the output sequencer.
// Depends on ucg_pkg.
module ucg_fifo #(
  parameter int DEPTH = ucg_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ucg_pkg::q_wr_t wr_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output ucg_pkg::job_t  head_o
);
  import ucg_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push    = wr_i.valid && !full_o;
  assign pop     = pop_i && valid_o;
  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_i.job;
    end
  end

endmodule

// File: rtl/ucg_back.sv
// ucg_back: output sequencer; expands queued jobs into result beats in an output register.
// Depends on ucg_pkg.
module ucg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  ucg_pkg::job_t                 head_i,
  output logic                          pop_o,
  input  logic [ucg_pkg::BYTE_W-1:0]    sync_byte_i,
  input  logic [ucg_pkg::BYTE_W-1:0]    end_byte_i,
  input  logic [ucg_pkg::CAN_ID_W-1:0]  reply_id_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          m_kind_o,
  output logic                          m_last_o,
  output logic [ucg_pkg::MBOX_W-1:0]    m_mailbox_o,
  output logic [ucg_pkg::PAYLOAD_W-1:0] m_payload_o,
  output logic [ucg_pkg::BYTE_W-1:0]    m_byte_o
);
  import ucg_pkg::*;

  localparam logic [3:0] BEAT_SYNC  = 4'd0;
  localparam logic [3:0] BEAT_ID0   = 4'd1;
  localparam logic [3:0] BEAT_ID1   = 4'd2;
  localparam logic [3:0] BEAT_ID2   = 4'd3;
  localparam logic [3:0] BEAT_ID3   = 4'd4;
  localparam logic [3:0] BEAT_DATA0 = 4'd5;
  localparam logic [3:0] BEAT_DATA7 = 4'd12;
  localparam logic [3:0] BEAT_END   = 4'(UART_BEATS - 1);

  logic       busy_q;
  logic [3:0] beat_q;
  job_t       job_q;
  logic       m_valid_q, m_kind_q, m_last_q;
  logic [MBOX_W-1:0]    m_mailbox_q;
  logic [PAYLOAD_W-1:0] m_payload_q;
  logic [BYTE_W-1:0]    m_byte_q;

  job_t        cur;
  logic [3:0]  beat;
  logic [2:0]  k;
  logic        have, out_free, fire, final_beat;
  logic [BYTE_W-1:0] uart_byte;

  assign cur        = busy_q ? job_q : head_i;
  assign beat       = busy_q ? beat_q : BEAT_SYNC;
  assign have       = busy_q || head_valid_i;
  assign out_free   = !m_valid_q || m_ready_i;
  assign fire       = have && out_free;
  assign final_beat = !cur.to_uart || (beat == BEAT_END);
  assign pop_o      = fire && !busy_q;
  assign k          = 3'(beat - BEAT_DATA0);

  always_comb begin
    case (beat) inside
      BEAT_SYNC:              uart_byte = sync_byte_i;
      BEAT_ID0, BEAT_ID1:     uart_byte = '0;
      BEAT_ID2:               uart_byte = BYTE_W'(reply_id_i[CAN_ID_W-1:BYTE_W]);
      BEAT_ID3:               uart_byte = reply_id_i[BYTE_W-1:0];
      [BEAT_DATA0:BEAT_DATA7]: uart_byte = cur.payload[(3'd7 - k) * 8 +: 8];
      BEAT_END:               uart_byte = end_byte_i;
      default:                uart_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      busy_q    <= 1'b0;
      beat_q    <= BEAT_SYNC;
    end else begin
      if (fire) begin
        m_valid_q <= 1'b1;
        if (final_beat) begin
          busy_q <= 1'b0;
        end else if (!busy_q) begin
          busy_q <= 1'b1;
          beat_q <= BEAT_ID0;
        end else begin
          beat_q <= beat_q + 1'b1;
        end
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !final_beat) begin
      job_q <= head_i;
    end
    if (fire) begin
      m_kind_q    <= cur.to_uart;
      m_last_q    <= final_beat;
      m_mailbox_q <= cur.to_uart ? '0 : cur.mailbox;
      m_payload_q <= cur.to_uart ? '0 : cur.payload;
      m_byte_q    <= cur.to_uart ? uart_byte : '0;
    end
  end

  assign m_valid_o   = m_valid_q;
  assign m_kind_o    = m_kind_q;
  assign m_last_o    = m_last_q;
  assign m_mailbox_o = m_mailbox_q;
  assign m_payload_o = m_payload_q;
  assign m_byte_o    = m_byte_q;

endmodule

// File: rtl/uart_can_frame_gateway_unit.sv
// uart_can_frame_gateway_unit: top level of the UART/CAN frame gateway.
// Depends on ucg_pkg, ucg_front, ucg_fifo and ucg_back.
//
// Slave stream: tuser selects the source (0 = UART byte, 1 = CAN frame); tdata carries the
// UART byte, the CAN ID and the 8 CAN data bytes. Master stream: tuser is the result kind
// (0 = CAN transmit request, 1 = UART byte), tlast marks the final beat of a result run.
// A UART frame is a sync byte and FRAME_BYTES bytes; a table hit gives one CAN request.
// A CAN frame with the reply ID gives 14 UART beats: sync, 4 ID bytes, 8 data bytes, end.
// Configuration: cfg_we_i writes register cfg_index_i (0 sync, 1 end, 2 reply ID) at once.
// Throughput: one input beat per cycle while the two-entry job queue has room; one output
// beat per cycle while the master side is ready.
// A completed job is first written into the job queue, then the output sequencer takes it
// into the output register that drives the master side.
// Reset: parser returns to waiting for sync, registers take their defaults, the queue and the
// output register empty.
// Master stall: the output register holds its beat; the queue fills, then tready drops.
module uart_can_frame_gateway_unit #(
  parameter int FRAME_BYTES   = ucg_pkg::FRAME_BYTES_DEF,
  parameter int TABLE_ENTRIES = ucg_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic                           s_axis_tuser_i,  // func
  input  logic [ucg_pkg::S_DATA_W-1:0]   s_axis_tdata_i,  // rx_byte, frame_id, frame_payload
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic                           m_axis_tuser_o,  // kind
  output logic                           m_axis_tlast_o,  // last
  output logic [ucg_pkg::M_DATA_W-1:0]   m_axis_tdata_o,  // mailbox, tx_payload, tx_byte
  input  logic                           cfg_we_i,
  input  logic [ucg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ucg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ucg_pkg::*;

  logic [BYTE_W-1:0]   sync_byte_q, end_byte_q;
  logic [CAN_ID_W-1:0] reply_id_q;
  q_wr_t               q_wr;
  job_t                head;
  logic                q_full, q_valid, pop, accept;
  logic                m_kind, m_last;
  logic [MBOX_W-1:0]    m_mailbox;
  logic [PAYLOAD_W-1:0] m_payload;
  logic [BYTE_W-1:0]    m_byte;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= 8'd128;
      end_byte_q  <= 8'd13;
      reply_id_q  <= 11'd368;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SYNC:  sync_byte_q <= cfg_data_i[BYTE_W-1:0];
        CFG_END:   end_byte_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_REPLY: reply_id_q  <= cfg_data_i[CAN_ID_W-1:0];
        default: ;
      endcase
    end
  end

  ucg_front #(
    .FRAME_BYTES  (FRAME_BYTES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .func_i     (s_axis_tuser_i),
    .rx_byte_i  (s_axis_tdata_i[7:0]),
    .frame_id_i (s_axis_tdata_i[18:8]),
    .payload_i  (s_axis_tdata_i[82:19]),
    .sync_byte_i(sync_byte_q),
    .reply_id_i (reply_id_q),
    .q_wr_o     (q_wr)
  );

  ucg_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (head)
  );

  ucg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .sync_byte_i (sync_byte_q),
    .end_byte_i  (end_byte_q),
    .reply_id_i  (reply_id_q),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_kind_o    (m_kind),
    .m_last_o    (m_last),
    .m_mailbox_o (m_mailbox),
    .m_payload_o (m_payload),
    .m_byte_o    (m_byte)
  );

  assign m_axis_tuser_o = m_kind;
  assign m_axis_tlast_o = m_last;
  assign m_axis_tdata_o = {4'b0, m_byte, m_payload, m_mailbox};

endmodule

// File: rtl/ucg_checker.sv
// ucg_checker: port-level assertions for uart_can_frame_gateway_unit, with its bind.
// Depends on ucg_pkg.
module ucg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic                           m_axis_tuser_o,
  input logic                           m_axis_tlast_o,
  input logic [ucg_pkg::M_DATA_W-1:0]   m_axis_tdata_o
);
  import ucg_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  a_can_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o[75:68] == 8'd0)
    else $error("CAN request beat not single or carries a byte");

  a_uart_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[67:0] == 68'd0)
    else $error("UART beat carries mailbox or payload");

  a_mbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[3:0] < MBOX_W'(ID_TABLE_LEN))
    else $error("mailbox outside ID table");

endmodule

bind uart_can_frame_gateway_unit ucg_checker u_ucg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o),
  .m_axis_tdata_o (m_axis_tdata_o)
);
